// ----- design/tbjt_pkg.sv -----
// ----------------------------------------------------------------------------
// tbjt_pkg
// Shared constants, codes and structures of the brute-force tour search unit.
// ----------------------------------------------------------------------------
package tbjt_pkg;

  localparam int NV = 16;
  localparam int VW = 4;
  localparam int ML = 8;
  localparam int IW = 3;
  localparam int LW = 4;
  localparam int WB = 16;
  localparam int CW = 20;
  localparam int AW = 2 * VW;

  typedef enum logic [1:0] {
    ACT_EDGE   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_SOLVE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_COST,
    S_TAIL,
    S_CMP,
    S_FIND,
    S_SWAP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic rotate;
    logic wrap;
    logic flip;
    logic take_left;
    logic take_right;
    logic keep_best;
    logic visit_wr;
    logic has_left;
    logic has_right;
  } cell_ctrl_t;

  typedef struct packed {
    logic [VW-1:0] left_val;
    logic          left_dir;
    logic [VW-1:0] right_val;
    logic          right_dir;
    logic [VW-1:0] ring_val;
    logic [VW-1:0] moved;
    logic [VW-1:0] visit_data;
  } cell_in_t;

endpackage

// ----- design/tbjt_cell.sv -----
// ----------------------------------------------------------------------------
// tbjt_cell
// One position of the visiting order: list entry, current entry, direction
// and best entry, with local mobility detection and neighbour exchange.
// ----------------------------------------------------------------------------
module tbjt_cell (
  input  logic                   clk_i,
  input  tbjt_pkg::cell_ctrl_t   ctrl_i,
  input  tbjt_pkg::cell_in_t     data_i,
  output logic [tbjt_pkg::VW-1:0] val_o,
  output logic                   dir_o,
  output logic [tbjt_pkg::VW-1:0] best_o,
  output logic [tbjt_pkg::VW-1:0] visit_o,
  output logic                   mobile_o
);

  logic [tbjt_pkg::VW-1:0] val_q, val_d;
  logic                    dir_q, dir_d;
  logic [tbjt_pkg::VW-1:0] best_q;
  logic [tbjt_pkg::VW-1:0] visit_q;

  always_comb begin
    val_d = val_q;
    dir_d = dir_q;
    if (ctrl_i.load) begin
      val_d = visit_q;
      dir_d = 1'b0;
    end else if (ctrl_i.rotate) begin
      val_d = ctrl_i.wrap ? data_i.ring_val : data_i.right_val;
    end else if (ctrl_i.flip) begin
      if (ctrl_i.take_right) begin
        val_d = data_i.right_val;
        dir_d = data_i.right_dir;
      end else if (ctrl_i.take_left) begin
        val_d = data_i.left_val;
        dir_d = data_i.left_dir;
      end
      dir_d = dir_d ^ (val_d > data_i.moved);
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    dir_q <= dir_d;
    if (ctrl_i.keep_best) begin
      best_q <= val_q;
    end
    if (ctrl_i.visit_wr) begin
      visit_q <= data_i.visit_data;
    end
  end

  assign val_o    = val_q;
  assign dir_o    = dir_q;
  assign best_o   = best_q;
  assign visit_o  = visit_q;
  assign mobile_o = dir_q ? (ctrl_i.has_right && (val_q > data_i.right_val))
                          : (ctrl_i.has_left && (val_q > data_i.left_val));

endmodule

// ----- design/tbjt_weight_ram.sv -----
// ----------------------------------------------------------------------------
// tbjt_weight_ram
// Symmetric edge weight store, one entry per unordered vertex pair, with a
// valid bit per entry so that an unwritten edge reads as zero.
// ----------------------------------------------------------------------------
module tbjt_weight_ram (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [tbjt_pkg::AW-1:0] waddr_i,
  input  logic [tbjt_pkg::WB-1:0] wdata_i,
  input  logic [tbjt_pkg::AW-1:0] raddr_i,
  output logic [tbjt_pkg::WB-1:0] rdata_o
);

  localparam int Depth = 1 << tbjt_pkg::AW;

  logic [tbjt_pkg::WB-1:0] mem [Depth];
  logic [Depth-1:0]        vld_q;
  logic [tbjt_pkg::WB-1:0] rd_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ----- design/tsp_brute_force_johnson_trotter_unit.sv -----
// ----------------------------------------------------------------------------
// tsp_brute_force_johnson_trotter_unit
// Each load item gives one result. A solve of n vertices makes one weight
// memory read per tour edge and one cell scan per step, then gives n results,
// one per cycle when not stalled.
// Reset clears the list length, the edge valid bits and all control state.
// ----------------------------------------------------------------------------
module tsp_brute_force_johnson_trotter_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              action_i,
  input  logic [3:0]              vertex_a_i,
  input  logic [3:0]              vertex_b_i,
  input  logic signed [15:0]      weight_i,
  input  logic [3:0]              visit_vertex_i,
  input  logic [3:0]              start_vertex_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic [3:0]              route_vertex_o,
  output logic [2:0]              route_position_o,
  output logic signed [19:0]      route_cost_o,
  output logic                    last_o
);

  localparam int ML = tbjt_pkg::ML;
  localparam int VW = tbjt_pkg::VW;
  localparam int IW = tbjt_pkg::IW;
  localparam int LW = tbjt_pkg::LW;
  localparam int CW = tbjt_pkg::CW;
  localparam int WB = tbjt_pkg::WB;
  localparam int AW = tbjt_pkg::AW;

  tbjt_pkg::state_e state_q, state_d;

  logic [LW-1:0]        len_q, len_d;
  logic [VW-1:0]        start_q, start_d;
  logic [VW-1:0]        prev_q, prev_d;
  logic [LW-1:0]        e_q, e_d;
  logic [IW-1:0]        i_q, i_d;
  logic                 rd_pend_q, rd_pend_d;
  logic                 first_q, first_d;
  logic                 found_q, found_d;
  logic [VW-1:0]        bval_q, bval_d;
  logic [IW-1:0]        bidx_q, bidx_d;
  logic signed [CW-1:0] acc_q, acc_d;
  logic signed [CW-1:0] best_q, best_d;

  logic                 ov_q, ov_d;
  logic [1:0]           st_q, st_d;
  logic [VW-1:0]        rv_q, rv_d;
  logic [IW-1:0]        rp_q, rp_d;
  logic signed [CW-1:0] rc_q, rc_d;
  logic                 rl_q, rl_d;

  tbjt_pkg::cell_ctrl_t ctrl [ML];
  tbjt_pkg::cell_in_t   cin  [ML];
  logic [VW-1:0]        val   [ML];
  logic                 dir   [ML];
  logic [VW-1:0]        best  [ML];
  logic [VW-1:0]        visit [ML];
  logic                 mobile[ML];

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [WB-1:0]        rdata;
  logic [VW-1:0]        ra, rb;
  logic signed [CW-1:0] w_ext;
  logic                 accept, out_free, dup, bad;
  logic                 load, rotate, flip, keep_best, app_wr;
  logic [IW-1:0]        lo;

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != tbjt_pkg::S_IDLE) || (ov_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < ML; k++) begin
      if ((LW'(k) < len_q) && (visit[k] == visit_vertex_i)) begin
        dup = 1'b1;
      end
    end
  end
  assign bad = (len_q >= LW'(ML)) || dup;

  assign waddr = (vertex_a_i < vertex_b_i) ? {vertex_a_i, vertex_b_i}
                                           : {vertex_b_i, vertex_a_i};
  assign raddr = (ra < rb) ? {ra, rb} : {rb, ra};
  assign w_ext = CW'(signed'(rdata));

  tbjt_weight_ram u_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(weight_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  for (genvar g = 0; g < ML; g++) begin : g_cell
    always_comb begin
      ctrl[g].load       = load;
      ctrl[g].rotate     = rotate;
      ctrl[g].wrap       = (LW'(g) + LW'(1) == len_q);
      ctrl[g].flip       = flip;
      ctrl[g].take_right = flip && (lo == IW'(g));
      ctrl[g].take_left  = flip && (g != 0) && (lo == IW'(g - 1));
      ctrl[g].keep_best  = keep_best;
      ctrl[g].visit_wr   = app_wr && (len_q[IW-1:0] == IW'(g));
      ctrl[g].has_left   = (g != 0);
      ctrl[g].has_right  = (LW'(g) + LW'(1) < len_q);
      cin[g].left_val    = (g != 0) ? val[(g + ML - 1) % ML] : '0;
      cin[g].left_dir    = (g != 0) ? dir[(g + ML - 1) % ML] : 1'b0;
      cin[g].right_val   = (g != ML - 1) ? val[(g + 1) % ML] : val[0];
      cin[g].right_dir   = (g != ML - 1) ? dir[(g + 1) % ML] : dir[0];
      cin[g].ring_val    = val[0];
      cin[g].moved       = bval_q;
      cin[g].visit_data  = visit_vertex_i;
    end

    tbjt_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .data_i  (cin[g]),
      .val_o   (val[g]),
      .dir_o   (dir[g]),
      .best_o  (best[g]),
      .visit_o (visit[g]),
      .mobile_o(mobile[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    start_d   = start_q;
    prev_d    = prev_q;
    e_d       = e_q;
    i_d       = i_q;
    rd_pend_d = 1'b0;
    first_d   = first_q;
    found_d   = found_q;
    bval_d    = bval_q;
    bidx_d    = bidx_q;
    acc_d     = rd_pend_q ? acc_q + w_ext : acc_q;
    best_d    = best_q;
    ov_d      = ov_q && out_stall_i;
    st_d      = st_q;
    rv_d      = rv_q;
    rp_d      = rp_q;
    rc_d      = rc_q;
    rl_d      = rl_q;
    we        = 1'b0;
    load      = 1'b0;
    rotate    = 1'b0;
    flip      = 1'b0;
    keep_best = 1'b0;
    app_wr    = 1'b0;
    ra        = prev_q;
    rb        = val[0];
    lo        = dir[bidx_q] ? bidx_q : bidx_q - IW'(1);

    case (state_q)
      tbjt_pkg::S_IDLE: begin
        if (accept) begin
          ov_d = 1'b1;
          st_d = tbjt_pkg::ST_OK;
          rv_d = '0;
          rp_d = '0;
          rc_d = '0;
          rl_d = 1'b1;
          case (tbjt_pkg::action_e'(action_i))
            tbjt_pkg::ACT_EDGE: begin
              we = 1'b1;
            end
            tbjt_pkg::ACT_APPEND: begin
              if (bad) begin
                st_d = tbjt_pkg::ST_REFUSED;
              end else begin
                app_wr = 1'b1;
                len_d  = len_q + LW'(1);
              end
            end
            tbjt_pkg::ACT_CLEAR: begin
              len_d = '0;
            end
            tbjt_pkg::ACT_SOLVE: begin
              if (len_q == '0) begin
                st_d = tbjt_pkg::ST_EMPTY;
              end else begin
                ov_d    = ov_q && out_stall_i;
                start_d = start_vertex_i;
                state_d = tbjt_pkg::S_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tbjt_pkg::S_LOAD: begin
        load    = 1'b1;
        first_d = 1'b1;
        e_d     = '0;
        acc_d   = '0;
        state_d = tbjt_pkg::S_COST;
      end
      tbjt_pkg::S_COST: begin
        ra        = (e_q == '0) ? start_q : prev_q;
        rb        = (e_q == len_q) ? start_q : val[0];
        rd_pend_d = 1'b1;
        e_d       = e_q + LW'(1);
        if (e_q == len_q) begin
          state_d = tbjt_pkg::S_TAIL;
        end else begin
          rotate = 1'b1;
          prev_d = val[0];
        end
      end
      tbjt_pkg::S_TAIL: begin
        state_d = tbjt_pkg::S_CMP;
      end
      tbjt_pkg::S_CMP: begin
        if (first_q || (acc_q < best_q)) begin
          best_d    = acc_q;
          keep_best = 1'b1;
        end
        first_d = 1'b0;
        found_d = 1'b0;
        i_d     = '0;
        state_d = tbjt_pkg::S_FIND;
      end
      tbjt_pkg::S_FIND: begin
        if (mobile[i_q] && (!found_q || (val[i_q] > bval_q))) begin
          found_d = 1'b1;
          bval_d  = val[i_q];
          bidx_d  = i_q;
        end
        i_d = i_q + IW'(1);
        if ({1'b0, i_q} + LW'(1) == len_q) begin
          state_d = tbjt_pkg::S_SWAP;
        end
      end
      tbjt_pkg::S_SWAP: begin
        if (found_q) begin
          flip    = 1'b1;
          e_d     = '0;
          acc_d   = '0;
          state_d = tbjt_pkg::S_COST;
        end else begin
          i_d     = '0;
          state_d = tbjt_pkg::S_OUT;
        end
      end
      tbjt_pkg::S_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          st_d = tbjt_pkg::ST_OK;
          rv_d = best[i_q];
          rp_d = i_q;
          rc_d = best_q;
          rl_d = ({1'b0, i_q} + LW'(1) == len_q);
          i_d  = i_q + IW'(1);
          if ({1'b0, i_q} + LW'(1) == len_q) begin
            state_d = tbjt_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = tbjt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tbjt_pkg::S_IDLE;
      len_q     <= '0;
      e_q       <= '0;
      i_q       <= '0;
      rd_pend_q <= 1'b0;
      first_q   <= 1'b0;
      found_q   <= 1'b0;
      best_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      e_q       <= e_d;
      i_q       <= i_d;
      rd_pend_q <= rd_pend_d;
      first_q   <= first_d;
      found_q   <= found_d;
      best_q    <= best_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    prev_q  <= prev_d;
    bval_q  <= bval_d;
    bidx_q  <= bidx_d;
    acc_q   <= acc_d;
    st_q    <= st_d;
    rv_q    <= rv_d;
    rp_q    <= rp_d;
    rc_q    <= rc_d;
    rl_q    <= rl_d;
  end

  assign out_valid_o      = ov_q;
  assign status_o         = st_q;
  assign route_vertex_o   = rv_q;
  assign route_position_o = rp_q;
  assign route_cost_o     = rc_q;
  assign last_o           = rl_q;

endmodule
